@@ rtl/fbr_pkg.sv @@
`timescale 1ns / 1ps
package fbr_pkg;

  // Trail length limit used as the default of the top-level parameter.
  localparam int DefMaxPoints = 32768;

  // Widths of the bit-serial arithmetic units.
  localparam int MulW     = 32;
  localparam int ProdW    = 2 * MulW;
  localparam int DivNumW  = 64;
  localparam int DivDenW  = 32;
  localparam int SqrtInW  = 62;
  localparam int SqrtOutW = SqrtInW / 2;

  // Configuration registers.
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 31;
  localparam logic [CfgIdxW-1:0] RegRibbonWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPointTotal  = 1'b1;
  localparam logic [30:0] RibbonWidthReset = 31'd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] left_z;
    logic signed [31:0] right_x;
    logic signed [31:0] right_z;
    logic signed [31:0] vertex_height;
    logic signed [31:0] tex_v;
    logic [1:0]         alpha_thirds;
    logic               make_quad;
    logic [15:0]        quad_base;
    logic               run_end;
  } out_item_t;

endpackage

@@ rtl/fbr_mul.sv @@
`timescale 1ns / 1ps
module fbr_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbr_pkg::MulW-1:0]   a_i,
  input  logic [fbr_pkg::MulW-1:0]   b_i,
  output logic                       done_o,
  output logic [fbr_pkg::ProdW-1:0]  prod_o
);
  import fbr_pkg::*;

  localparam int CntW = $clog2(MulW);

  logic [ProdW-1:0] prod_q, prod_d;
  logic [MulW-1:0]  b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MulW:0]    sum;

  // One multiplier bit per cycle: add into the upper half, then shift right.
  always_comb begin
    sum    = {1'b0, prod_q[ProdW-1:MulW]} + (prod_q[0] ? {1'b0, b_q} : '0);
    prod_d = prod_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = {{MulW{1'b0}}, a_i};
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[MulW-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(MulW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    b_q    <= b_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ rtl/fbr_div.sv @@
`timescale 1ns / 1ps
module fbr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fbr_pkg::DivNumW-1:0]  num_i,
  input  logic [fbr_pkg::DivDenW-1:0]  den_i,
  output logic                         done_o,
  output logic [fbr_pkg::DivNumW-1:0]  quo_o
);
  import fbr_pkg::*;

  localparam int CntW = $clog2(DivNumW);

  logic [DivDenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivDenW:0]   trial, diff;
  logic               ge;

  // Restoring division, one quotient bit per cycle. The quotient bits shift
  // into the numerator register as its bits move into the remainder.
  always_comb begin
    trial  = {rem_q, num_q[DivNumW-1]};
    ge     = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      num_d = {num_q[DivNumW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

@@ rtl/fbr_sqrt.sv @@
`timescale 1ns / 1ps
module fbr_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fbr_pkg::SqrtInW-1:0]   rad_i,
  output logic                          done_o,
  output logic [fbr_pkg::SqrtOutW-1:0]  root_o
);
  import fbr_pkg::*;

  localparam int CntW = $clog2(SqrtOutW);
  localparam int RemW = SqrtOutW + 2;

  logic [SqrtInW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [SqrtOutW-1:0] root_q, root_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [RemW+1:0]     r2, trial, diff;

  // Floor square root, two radicand bits and one root bit per cycle.
  always_comb begin
    r2     = {rem_q, rad_q[SqrtInW-1:SqrtInW-2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = r2 - trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SqrtInW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_d  = diff[RemW-1:0];
        root_d = {root_q[SqrtOutW-2:0], 1'b1};
      end else begin
        rem_d  = r2[RemW-1:0];
        root_d = {root_q[SqrtOutW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(SqrtOutW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ rtl/flat_ribbon_strip_from_waypoints.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (waypoint)
// out       output     out_valid_o / out_ready_i  out_data_o (vertex pair)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A waypoint that produces no vertex pair passes only the step states. For each
// pair, every multiply, square root and division runs on shared
// one-bit-per-cycle units, with up to three 64-step divisions (two direction
// components and the texture coordinate).
// Reset clears the trail state at once; there is no clearing pass.
// A finished pair waits in the output register while the next waypoint is
// taken; a second pair of the same waypoint waits for that register to free.
module flat_ribbon_strip_from_waypoints #(
  parameter int MAX_POINTS = fbr_pkg::DefMaxPoints
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fbr_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fbr_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [fbr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fbr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fbr_pkg::*;

  // Point counter and indices hold values up to MAX_POINTS itself.
  localparam int CntW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_STEP1  = 5'd1;
  localparam logic [4:0] S_STEP2  = 5'd2;
  localparam logic [4:0] S_STEP3  = 5'd3;
  localparam logic [4:0] S_DIR    = 5'd4;
  localparam logic [4:0] S_NORM   = 5'd5;
  localparam logic [4:0] S_SQA    = 5'd6;
  localparam logic [4:0] S_SQB    = 5'd7;
  localparam logic [4:0] S_SQRTL  = 5'd8;
  localparam logic [4:0] S_DIVX   = 5'd9;
  localparam logic [4:0] S_DIVZ   = 5'd10;
  localparam logic [4:0] S_MULZ   = 5'd11;
  localparam logic [4:0] S_MULX   = 5'd12;
  localparam logic [4:0] S_DIST   = 5'd13;
  localparam logic [4:0] S_DSHIFT = 5'd14;
  localparam logic [4:0] S_DSQX   = 5'd15;
  localparam logic [4:0] S_DSQY   = 5'd16;
  localparam logic [4:0] S_DSQZ   = 5'd17;
  localparam logic [4:0] S_DSQRT  = 5'd18;
  localparam logic [4:0] S_TEX    = 5'd19;
  localparam logic [4:0] S_EMIT   = 5'd20;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  // Clamp a 34-bit signed value into the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) sat32 = v[31:0];
    else if (v[33]) sat32 = 32'h8000_0000;
    else sat32 = 32'h7FFF_FFFF;
  endfunction

  // Configuration.
  logic [30:0] ribbon_w_q;
  logic [15:0] point_total_q;

  // Trail state.
  logic [4:0]          state_q, state_d;
  logic signed [31:0]  held_x_q, held_x_d, held_y_q, held_y_d, held_z_q, held_z_d;
  logic                held_present_q, held_present_d, held_opens_q, held_opens_d;
  logic [CntW-1:0]     held_index_q, held_index_d;
  logic signed [31:0]  ear_x_q, ear_x_d, ear_y_q, ear_y_d, ear_z_q, ear_z_d;
  logic                ear_present_q, ear_present_d;
  logic [47:0]         dist_sum_q, dist_sum_d;
  logic [15:0]         pairs_q, pairs_d;
  logic                break_seen_q, break_seen_d;
  logic [CntW-1:0]     point_cnt_q, point_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                issued_q, issued_d;

  // Working registers of the current waypoint and pair.
  logic signed [31:0]  px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic                fin_q, fin_d, job_b_q, job_b_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic signed [32:0]  dx_q, dx_d, dz_q, dz_d;
  logic [32:0]         am_q, am_d, bm_q, bm_d, cm_q, cm_d;
  logic                sx_q, sx_d, sz_q, sz_d, near_q, near_d;
  logic [1:0]          k_q, k_d;
  logic [SqrtInW-1:0]  sq_q, sq_d;
  logic [SqrtOutW-1:0] len_q, len_d;
  logic [30:0]         cmx_q, cmx_d, cmz_q, cmz_d;
  logic signed [31:0]  rx_q, rx_d, rz_q, rz_d;
  logic [31:0]         vmag_q, vmag_d;
  out_item_t           out_q, out_d;

  // Shared units.
  logic               mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   mul_prod;
  logic [DivNumW-1:0] div_num, div_quo;
  logic [DivDenW-1:0] div_den;
  logic [SqrtInW-1:0] sqrt_rad;
  logic [SqrtOutW-1:0] sqrt_root;

  fbr_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  fbr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  fbr_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(sqrt_rad),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  // Combinational helpers for the current state.
  logic [32:0]        dir_a, dir_b, max_ab;
  logic [5:0]         sqa3, sqb3;
  logic               near_dir;
  logic               pt_valid, show;
  logic [ProdW-1:0]   rnd_sum;
  logic [31:0]        mr;
  logic [33:0]        step_len;
  logic [48:0]        dist_acc;
  logic [16:0]        n_pts;
  logic signed [17:0] n_s, i_s, tail;
  logic [1:0]         alpha;
  logic               quad;

  always_comb begin
    dir_a    = mag33(dx_q);
    dir_b    = mag33(dz_q);
    sqa3     = {3'b000, dir_a[2:0]} * {3'b000, dir_a[2:0]};
    sqb3     = {3'b000, dir_b[2:0]} * {3'b000, dir_b[2:0]};
    near_dir = (dir_a < 33'd8) && (dir_b < 33'd8) &&
               (({1'b0, sqa3} + {1'b0, sqb3}) <= 7'd42);
    max_ab   = (am_q > bm_q) ? am_q : bm_q;
    pt_valid = (px_q != '0) || (py_q != '0) || (pz_q != '0);
    show     = point_total_q >= 16'd2;

    // Offset rounding: nearest on the magnitude, ties away from zero.
    rnd_sum  = mul_prod + (near_q ? 64'd65536 : 64'h4000_0000);
    mr       = near_q ? rnd_sum[48:17] : rnd_sum[62:31];

    step_len = {3'b000, sqrt_root} << k_q;
    dist_acc = {1'b0, dist_sum_q} + {15'd0, step_len};

    // Alpha fade over the first and last three indices.
    n_pts = ({1'b0, point_total_q} > 17'(MAX_POINTS)) ? 17'(MAX_POINTS)
                                                      : {1'b0, point_total_q};
    n_s   = $signed({1'b0, n_pts});
    i_s   = $signed({{(18 - CntW){1'b0}}, held_index_q});
    tail  = n_s - 18'sd1 - i_s;
    if (i_s < 18'sd3) alpha = i_s[1:0];
    else if (i_s >= n_s - 18'sd3) alpha = tail[17] ? 2'd0 : tail[1:0];
    else alpha = 2'd3;
    quad = !held_opens_q && (pairs_q != 16'd0);
  end

  always_comb begin
    state_d        = state_q;
    held_x_d       = held_x_q;
    held_y_d       = held_y_q;
    held_z_d       = held_z_q;
    held_present_d = held_present_q;
    held_opens_d   = held_opens_q;
    held_index_d   = held_index_q;
    ear_x_d        = ear_x_q;
    ear_y_d        = ear_y_q;
    ear_z_d        = ear_z_q;
    ear_present_d  = ear_present_q;
    dist_sum_d     = dist_sum_q;
    pairs_d        = pairs_q;
    break_seen_d   = break_seen_q;
    point_cnt_d    = point_cnt_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    issued_d       = issued_q;
    px_d = px_q;  py_d = py_q;  pz_d = pz_q;
    fin_d = fin_q;  job_b_d = job_b_q;  idx_d = idx_q;
    dx_d = dx_q;  dz_d = dz_q;
    am_d = am_q;  bm_d = bm_q;  cm_d = cm_q;
    sx_d = sx_q;  sz_d = sz_q;  near_d = near_q;  k_d = k_q;
    sq_d = sq_q;  len_d = len_q;  cmx_d = cmx_q;  cmz_d = cmz_q;
    rx_d = rx_q;  rz_d = rz_q;  vmag_d = vmag_q;
    out_d = out_q;
    mul_start = 1'b0;  mul_a = '0;  mul_b = '0;
    div_start = 1'b0;  div_num = '0;  div_den = '0;
    sqrt_start = 1'b0;  sqrt_rad = sq_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d  = in_data_i.pos_x;
          py_d  = in_data_i.pos_y;
          pz_d  = in_data_i.pos_z;
          fin_d = in_data_i.final_point;
          idx_d = point_cnt_q;
          if (point_cnt_q < CntW'(MAX_POINTS)) point_cnt_d = point_cnt_q + 1'b1;
          state_d = S_STEP1;
        end
      end
      S_STEP1: begin
        // A new valid point closes the held one: its direction points here.
        if (pt_valid && held_present_q) begin
          dx_d    = $signed({px_q[31], px_q}) - $signed({held_x_q[31], held_x_q});
          dz_d    = $signed({pz_q[31], pz_q}) - $signed({held_z_q[31], held_z_q});
          job_b_d = 1'b0;
          state_d = S_DIR;
        end else begin
          state_d = S_STEP2;
        end
      end
      S_STEP2: begin
        if (pt_valid) begin
          held_x_d       = px_q;
          held_y_d       = py_q;
          held_z_d       = pz_q;
          held_index_d   = idx_q;
          held_opens_d   = break_seen_q;
          held_present_d = 1'b1;
          break_seen_d   = 1'b0;
        end else begin
          break_seen_d = 1'b1;
        end
        state_d = S_STEP3;
      end
      S_STEP3: begin
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (held_present_q) begin
          // Flush: direction from the earlier point, or along +X alone.
          if (ear_present_q) begin
            dx_d = $signed({held_x_q[31], held_x_q}) - $signed({ear_x_q[31], ear_x_q});
            dz_d = $signed({held_z_q[31], held_z_q}) - $signed({ear_z_q[31], ear_z_q});
          end else begin
            dx_d = 33'sd65536;
            dz_d = '0;
          end
          job_b_d = 1'b1;
          state_d = S_DIR;
        end else begin
          held_x_d = '0;  held_y_d = '0;  held_z_d = '0;
          held_present_d = 1'b0;  held_index_d = '0;  held_opens_d = 1'b1;
          ear_x_d = '0;  ear_y_d = '0;  ear_z_d = '0;  ear_present_d = 1'b0;
          dist_sum_d = '0;  pairs_d = '0;  break_seen_d = 1'b1;  point_cnt_d = '0;
          state_d = S_IDLE;
        end
      end
      S_DIR: begin
        am_d   = dir_a;
        bm_d   = dir_b;
        sx_d   = dx_q[32];
        sz_d   = dz_q[32];
        near_d = near_dir;
        if (near_dir) begin
          // Very short direction: used as it is, without normalizing.
          cmx_d   = dir_a[30:0];
          cmz_d   = dir_b[30:0];
          state_d = S_MULZ;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // Bring the larger magnitude into [2^29, 2^30), one bit a cycle.
        if (max_ab[32:30] != 3'b000) begin
          am_d = am_q >> 1;
          bm_d = bm_q >> 1;
        end else if (!max_ab[29]) begin
          am_d = am_q << 1;
          bm_d = bm_q << 1;
        end else begin
          state_d = S_SQA;
        end
      end
      S_SQA, S_SQB, S_DSQX, S_DSQY, S_DSQZ: begin
        case (state_q)
          S_SQA, S_DSQX: mul_a = am_q[31:0];
          S_SQB, S_DSQY: mul_a = bm_q[31:0];
          default:       mul_a = cm_q[31:0];
        endcase
        mul_b = mul_a;
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          if (state_q == S_SQA || state_q == S_DSQX) sq_d = mul_prod[SqrtInW-1:0];
          else sq_d = sq_q + mul_prod[SqrtInW-1:0];
          case (state_q)
            S_SQA:   state_d = S_SQB;
            S_SQB:   state_d = S_SQRTL;
            S_DSQX:  state_d = S_DSQY;
            S_DSQY:  state_d = S_DSQZ;
            default: state_d = S_DSQRT;
          endcase
        end
      end
      S_SQRTL, S_DSQRT: begin
        if (!issued_q) begin
          sqrt_start = 1'b1;
          issued_d   = 1'b1;
        end else if (sqrt_done) begin
          issued_d = 1'b0;
          if (state_q == S_SQRTL) begin
            len_d   = sqrt_root;
            state_d = S_DIVX;
          end else begin
            dist_sum_d = dist_acc[48] ? {48{1'b1}} : dist_acc[47:0];
            state_d    = S_TEX;
          end
        end
      end
      S_DIVX, S_DIVZ: begin
        // Unit component in Q2.30, rounded to nearest.
        div_num = {4'b0000, (state_q == S_DIVX) ? am_q[29:0] : bm_q[29:0], 30'd0}
                  + {34'd0, len_q[SqrtOutW-1:1]};
        div_den = {1'b0, len_q};
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          if (state_q == S_DIVX) begin
            cmx_d   = div_quo[30:0];
            state_d = S_DIVZ;
          end else begin
            cmz_d   = div_quo[30:0];
            state_d = S_MULZ;
          end
        end
      end
      S_MULZ, S_MULX: begin
        mul_a = {1'b0, (state_q == S_MULZ) ? cmz_q : cmx_q};
        mul_b = {1'b0, ribbon_w_q};
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          // Perpendicular (-uz, ux) scaled to half the ribbon width.
          if (state_q == S_MULZ) begin
            rx_d    = sz_q ? $signed(mr) : -$signed(mr);
            state_d = S_MULX;
          end else begin
            rz_d    = sx_q ? -$signed(mr) : $signed(mr);
            state_d = S_DIST;
          end
        end
      end
      S_DIST: begin
        // Distance accumulates only between points of one section.
        if (!held_opens_q && ear_present_q) begin
          am_d = mag33($signed({held_x_q[31], held_x_q}) - $signed({ear_x_q[31], ear_x_q}));
          bm_d = mag33($signed({held_y_q[31], held_y_q}) - $signed({ear_y_q[31], ear_y_q}));
          cm_d = mag33($signed({held_z_q[31], held_z_q}) - $signed({ear_z_q[31], ear_z_q}));
          k_d     = '0;
          state_d = S_DSHIFT;
        end else begin
          state_d = S_TEX;
        end
      end
      S_DSHIFT: begin
        if (am_q[32:30] != 3'b000 || bm_q[32:30] != 3'b000 || cm_q[32:30] != 3'b000) begin
          am_d = am_q >> 1;
          bm_d = bm_q >> 1;
          cm_d = cm_q >> 1;
          k_d  = k_q + 1'b1;
        end else begin
          state_d = S_DSQX;
        end
      end
      S_TEX: begin
        div_num = {dist_sum_q, 16'd0};
        div_den = {1'b0, ribbon_w_q};
        if (dist_sum_q == '0) begin
          vmag_d  = '0;
          state_d = S_EMIT;
        end else if (ribbon_w_q == '0) begin
          vmag_d  = 32'h8000_0000;
          state_d = S_EMIT;
        end else if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          vmag_d   = (div_quo[DivNumW-1:31] != '0) ? 32'h8000_0000
                                                   : {1'b0, div_quo[30:0]};
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!show || !out_valid_q || out_ready_i) begin
          if (show) begin
            out_d.left_x        = sat32($signed({{2{held_x_q[31]}}, held_x_q})
                                        - $signed({{2{rx_q[31]}}, rx_q}));
            out_d.left_z        = sat32($signed({{2{held_z_q[31]}}, held_z_q})
                                        - $signed({{2{rz_q[31]}}, rz_q}));
            out_d.right_x       = sat32($signed({{2{held_x_q[31]}}, held_x_q})
                                        + $signed({{2{rx_q[31]}}, rx_q}));
            out_d.right_z       = sat32($signed({{2{held_z_q[31]}}, held_z_q})
                                        + $signed({{2{rz_q[31]}}, rz_q}));
            out_d.vertex_height = held_y_q;
            out_d.tex_v         = 32'd0 - vmag_q;
            out_d.alpha_thirds  = alpha;
            out_d.make_quad     = quad;
            out_d.quad_base     = quad ? {pairs_q[14:0] - 15'd1, 1'b0} : 16'd0;
            out_d.run_end       = job_b_q || !fin_q;
            out_valid_d         = 1'b1;
          end
          pairs_d = pairs_q + 16'd1;
          if (job_b_q) begin
            // End of trail: everything but the configuration starts over.
            held_x_d = '0;  held_y_d = '0;  held_z_d = '0;
            held_present_d = 1'b0;  held_index_d = '0;  held_opens_d = 1'b1;
            ear_x_d = '0;  ear_y_d = '0;  ear_z_d = '0;  ear_present_d = 1'b0;
            dist_sum_d = '0;  pairs_d = '0;  break_seen_d = 1'b1;  point_cnt_d = '0;
            state_d = S_IDLE;
          end else begin
            ear_x_d       = held_x_q;
            ear_y_d       = held_y_q;
            ear_z_d       = held_z_q;
            ear_present_d = 1'b1;
            state_d       = S_STEP2;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ribbon_w_q    <= RibbonWidthReset;
      point_total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRibbonWidth: ribbon_w_q    <= cfg_data_i;
        RegPointTotal:  point_total_q <= cfg_data_i[15:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      held_x_q       <= '0;
      held_y_q       <= '0;
      held_z_q       <= '0;
      held_present_q <= 1'b0;
      held_opens_q   <= 1'b1;
      held_index_q   <= '0;
      ear_x_q        <= '0;
      ear_y_q        <= '0;
      ear_z_q        <= '0;
      ear_present_q  <= 1'b0;
      dist_sum_q     <= '0;
      pairs_q        <= '0;
      break_seen_q   <= 1'b1;
      point_cnt_q    <= '0;
      out_valid_q    <= 1'b0;
      issued_q       <= 1'b0;
    end else begin
      state_q        <= state_d;
      held_x_q       <= held_x_d;
      held_y_q       <= held_y_d;
      held_z_q       <= held_z_d;
      held_present_q <= held_present_d;
      held_opens_q   <= held_opens_d;
      held_index_q   <= held_index_d;
      ear_x_q        <= ear_x_d;
      ear_y_q        <= ear_y_d;
      ear_z_q        <= ear_z_d;
      ear_present_q  <= ear_present_d;
      dist_sum_q     <= dist_sum_d;
      pairs_q        <= pairs_d;
      break_seen_q   <= break_seen_d;
      point_cnt_q    <= point_cnt_d;
      out_valid_q    <= out_valid_d;
      issued_q       <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;
    fin_q <= fin_d;  job_b_q <= job_b_d;  idx_q <= idx_d;
    dx_q <= dx_d;  dz_q <= dz_d;
    am_q <= am_d;  bm_q <= bm_d;  cm_q <= cm_d;
    sx_q <= sx_d;  sz_q <= sz_d;  near_q <= near_d;  k_q <= k_d;
    sq_q <= sq_d;  len_q <= len_d;  cmx_q <= cmx_d;  cmz_q <= cmz_d;
    rx_q <= rx_d;  rz_q <= rz_d;  vmag_q <= vmag_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
